// ===== rtl/bls_pkg.sv =====
// shared types and constants for the bounded stack with search
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

  // field widths fixed by the item format
  localparam int DATA_W = 32;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;
  localparam int CAP_W  = 5;

  // register port
  localparam int APB_DW = 32;
  localparam int ADDR_W = 3;
  localparam logic             REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET    = 5'd16;

  // action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_PEEK   = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_DUMP   = 3'd4
  } action_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // one result word as held in the output register
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_e                  status;
    logic                     found;
    logic [CNT_W-1:0]         match_count;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    logic                     is_full;
    logic                     last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/bls_if.sv =====
// valid/ready channel interfaces for the command and result words
`timescale 1ns / 1ps
`default_nettype none

interface bls_in_if;
  import bls_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] operand;

  modport source (output valid, action, operand, input ready);
  modport sink   (input valid, action, operand, output ready);
endinterface

interface bls_out_if;
  import bls_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic [STAT_W-1:0]        status;
  logic                     found;
  logic [CNT_W-1:0]         match_count;
  logic [CNT_W-1:0]         entry_count;
  logic                     is_empty;
  logic                     is_full;
  logic                     last;

  modport source (output valid, data, status, found, match_count, entry_count,
                  is_empty, is_full, last, input ready);
  modport sink   (input valid, data, status, found, match_count, entry_count,
                  is_empty, is_full, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/bls_ram.sv =====
// entry storage: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module bls_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [bls_pkg::DATA_W-1:0] wdata_i,
  input  wire logic                      re_i,
  input  wire logic [AW-1:0]             raddr_i,
  output logic      [bls_pkg::DATA_W-1:0] rdata_o
);
  import bls_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/bls_match.sv =====
// single compare-and-count unit used by the search walk
`timescale 1ns / 1ps
`default_nettype none

module bls_match #(
  parameter int CW = 5
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clr_i,
  input  wire logic                       en_i,
  input  wire logic [bls_pkg::DATA_W-1:0] entry_i,
  input  wire logic [bls_pkg::DATA_W-1:0] target_i,
  output logic      [CW-1:0]              cnt_o
);
  import bls_pkg::*;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          hit;

  // one compare per cycle, running count includes this cycle's hit
  assign hit   = en_i && (entry_i == target_i);
  assign cnt_o = cnt_q + CW'(hit);

  always_comb begin
    cnt_d = cnt_q;
    if (clr_i) begin
      cnt_d = '0;
    end else if (en_i) begin
      cnt_d = cnt_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bls_seq.sv =====
// command sequencer: fill level, entry walks and the output register
`timescale 1ns / 1ps
`default_nettype none

module bls_seq #(
  parameter int DEPTH = 16,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [bls_pkg::CAP_W-1:0] cap_i,
  bls_in_if.sink                         in_i,
  bls_out_if.source                      out_o,
  output logic      [CW-1:0]             fill_o
);
  import bls_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_DUMP = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [ACT_W-1:0]  act_q, act_d;
  logic [DATA_W-1:0] tgt_q, tgt_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [CW-1:0]     idx_q, idx_d;
  res_t              out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic [XW-1:0]     cap_x;
  logic [CW-1:0]     eff_cap;
  logic              out_free;
  logic              accept;
  logic [CW-1:0]     top_idx;
  logic [CW-1:0]     idx_dec;
  logic [CW-1:0]     fill_inc;
  logic              empty;

  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              m_clr;
  logic              m_en;
  logic [CW-1:0]     m_cnt;

  // build one result word, flags taken from the fill level after the command
  function automatic res_t mk_res(input logic [DATA_W-1:0] data, input status_e st,
                                  input logic [CW-1:0] mcnt, input logic [CW-1:0] fill,
                                  input logic last);
    res_t r;
    r.data        = data;
    r.status      = st;
    r.found       = (mcnt != '0);
    r.match_count = CNT_W'(mcnt);
    r.entry_count = CNT_W'(fill);
    r.is_empty    = (fill == '0);
    r.is_full     = (fill >= eff_cap);
    r.last        = last;
    return r;
  endfunction

  // effective capacity: zero acts as one, clipped to the storage depth
  always_comb begin
    cap_x = XW'(cap_i);
    if (cap_x == '0) begin
      eff_cap = CW'(1);
    end else if (cap_x > XW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(cap_x);
    end
  end

  assign out_free    = !out_vld_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && out_free;
  assign accept      = in_i.valid && in_i.ready;
  assign top_idx     = fill_q - CW'(1);
  assign idx_dec     = idx_q - CW'(1);
  assign fill_inc    = fill_q + CW'(1);
  assign empty       = (fill_q == '0);

  // sequencer
  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    tgt_d     = tgt_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !out_o.ready;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    m_clr     = 1'b0;
    m_en      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d = in_i.action;
          tgt_d = in_i.operand;
          unique case (in_i.action)
            ACT_PUSH: begin
              out_vld_d = 1'b1;
              if (fill_q < eff_cap) begin
                ram_we = 1'b1;
                fill_d = fill_inc;
                out_d  = mk_res('0, ST_OK, '0, fill_inc, 1'b1);
              end else begin
                out_d  = mk_res('0, ST_OVERFLOW, '0, fill_q, 1'b1);
              end
            end
            ACT_POP, ACT_PEEK: begin
              if (empty) begin
                out_vld_d = 1'b1;
                out_d     = mk_res('0, ST_EMPTY, '0, fill_q, 1'b1);
              end else begin
                ram_re    = 1'b1;
                ram_raddr = top_idx[AW-1:0];
                state_d   = S_READ;
              end
            end
            ACT_SEARCH: begin
              if (empty) begin
                out_vld_d = 1'b1;
                out_d     = mk_res('0, ST_EMPTY, '0, fill_q, 1'b1);
              end else begin
                ram_re    = 1'b1;
                idx_d     = CW'(1);
                m_clr     = 1'b1;
                state_d   = S_SCAN;
              end
            end
            ACT_DUMP: begin
              if (empty) begin
                out_vld_d = 1'b1;
                out_d     = mk_res('0, ST_EMPTY, '0, fill_q, 1'b1);
              end else begin
                ram_re    = 1'b1;
                ram_raddr = top_idx[AW-1:0];
                idx_d     = top_idx;
                state_d   = S_DUMP;
              end
            end
            default: begin
              out_vld_d = 1'b1;
              out_d     = mk_res('0, ST_OK, '0, fill_q, 1'b1);
            end
          endcase
        end
      end
      // top entry is back from the ram
      S_READ: begin
        out_vld_d = 1'b1;
        state_d   = S_IDLE;
        if (act_q == ACT_POP) begin
          fill_d = top_idx;
          out_d  = mk_res(ram_rdata, ST_OK, '0, top_idx, 1'b1);
        end else begin
          out_d  = mk_res(ram_rdata, ST_OK, '0, fill_q, 1'b1);
        end
      end
      // compare one entry a cycle, bottom to top
      S_SCAN: begin
        m_en = 1'b1;
        if (idx_q == fill_q) begin
          out_vld_d = 1'b1;
          out_d     = mk_res('0, ST_OK, m_cnt, fill_q, 1'b1);
          state_d   = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[AW-1:0];
          idx_d     = fill_q == '0 ? idx_q : idx_q + CW'(1);
        end
      end
      // emit one entry per free output slot, top to bottom
      S_DUMP: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = mk_res(ram_rdata, ST_OK, '0, fill_q, idx_q == '0);
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_dec[AW-1:0];
            idx_d     = idx_dec;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    tgt_q <= tgt_d;
    out_q <= out_d;
  end

  bls_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (in_i.operand),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bls_match #(
    .CW (CW)
  ) u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (m_clr),
    .en_i     (m_en),
    .entry_i  (ram_rdata),
    .target_i (tgt_q),
    .cnt_o    (m_cnt)
  );

  // result channel
  assign out_o.valid       = out_vld_q;
  assign out_o.data        = out_q.data;
  assign out_o.status      = out_q.status;
  assign out_o.found       = out_q.found;
  assign out_o.match_count = out_q.match_count;
  assign out_o.entry_count = out_q.entry_count;
  assign out_o.is_empty    = out_q.is_empty;
  assign out_o.is_full     = out_q.is_full;
  assign out_o.last        = out_q.last;

  assign fill_o = fill_q;

endmodule

`default_nettype wire

// ===== rtl/bounded_lifo_stack_with_search.sv =====
// top level: register port, sequencer and checks of the bounded stack
`timescale 1ns / 1ps
`default_nettype none

// Bounded LIFO stack of signed 32-bit words with push, pop, peek, search and dump.
// Commands come in on in_i and results leave on out_o; a command is taken only
// when the sequencer is idle and the output register is empty or being read.
// Push, an empty-stack command and an unused code produce their word at the
// accepting edge. Pop and peek pass through the registered read of the entry
// ram and then the S_READ state. Search walks the stored entries through a single
// compare-and-count unit, one entry per cycle. Dump emits one word per entry,
// top first, one per cycle while out_o is ready, with last set on the bottom
// entry. The capacity register (offset 0) limits how many entries a push may
// fill; 0 acts as 1 and values above DEPTH as DEPTH.
module bounded_lifo_stack_with_search #(
  parameter int DEPTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  bls_in_if.sink                            in_i,
  bls_out_if.source                         out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bls_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bls_pkg::APB_DW-1:0]   pwdata,
  output logic      [bls_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);
  import bls_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CAP_W-1:0] capacity_q, capacity_d;
  logic [CW-1:0]    fill;
  logic             reg_sel;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_CAPACITY);

  always_comb begin
    capacity_d = capacity_q;
    if (psel && penable && pwrite && reg_sel) begin
      capacity_d = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  assign prdata = reg_sel ? APB_DW'(capacity_q) : '0;

  bls_seq #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cap_i  (capacity_q),
    .in_i   (in_i),
    .out_o  (out_o),
    .fill_o (fill)
  );

  // fill level never exceeds the storage depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= CW'(DEPTH))
    else $error("fill level beyond depth");

  // fill level moves by at most one entry per cycle
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill == $past(fill)) || (fill == $past(fill) + CW'(1)) ||
    (fill == $past(fill) - CW'(1)))
    else $error("fill level jumped");

  // a command is only taken when the output slot can receive a word
  a_take_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (!out_o.valid || out_o.ready))
    else $error("command taken while result blocked");

  // empty flag agrees with the reported count
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.is_empty == (out_o.entry_count == '0)))
    else $error("empty flag mismatch");

endmodule

`default_nettype wire
